/* rtl/servo_status_packet_receiver_top_assert.svh */
// Assertion macros for the servo status packet receiver checker
`ifndef SERVO_STATUS_PACKET_RECEIVER_TOP_ASSERT_SVH
`define SERVO_STATUS_PACKET_RECEIVER_TOP_ASSERT_SVH

// Clocked assertion, switched off while reset is held
`define SSPRX_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication that is checked only while a result word is offered
`define SSPRX_ASSERT_OUT(label, cons, msg) \
	`SSPRX_ASSERT(label, m_axis_tvalid |-> (cons), msg)

`endif

/* rtl/ssprx_pkg.sv */
// Shared types and constants for the servo status packet receiver
package ssprx_pkg;

	localparam int unsigned ACTION_W = 2;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned INDEX_W  = 9;
	localparam int unsigned TICK_W   = 16;

	localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_BYTE  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

	localparam logic [TICK_W-1:0]  TIMEOUT_RESET = 16'd2000;
	localparam logic [INDEX_W-1:0] HEADER_EXTRA  = 9'd4;
	localparam logic [INDEX_W-1:0] LENGTH_INDEX  = 9'd3;
	localparam logic [INDEX_W-1:0] SUM_FIRST     = 9'd2;
	localparam logic [TICK_W-1:0]  TICK_MAX      = 16'hFFFF;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [BYTE_W-1:0]   data_byte;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  rx_byte;
		logic [INDEX_W-1:0] byte_index;
		logic               last;
		logic               checksum_error;
		logic               timed_out;
	} result_t;

endpackage

/* rtl/ssprx_in_stage.sv */
// Input register for incoming action words
module ssprx_in_stage
	import ssprx_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  take,
	output logic  valid_s1,
	output item_t item_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

/* rtl/ssprx_core.sv */
// Packet state, checksum, timeout and result formation
module ssprx_core
	import ssprx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [TICK_W-1:0] cfg_wr_data,
	input  logic              valid_s1,
	input  item_t             item_s1,
	input  logic              out_free,
	output logic              take,
	output logic              res_valid,
	output result_t           res
);

	logic [TICK_W-1:0]  timeout_limit_q;
	logic               receiving_q;
	logic [INDEX_W-1:0] byte_count_q;
	logic [INDEX_W-1:0] packet_total_q;
	logic [BYTE_W-1:0]  running_sum_q;
	logic [TICK_W-1:0]  tick_count_q;

	logic [INDEX_W-1:0] total_next;
	logic [INDEX_W:0]   idx_plus;
	logic               is_last;
	logic [TICK_W-1:0]  tick_next;
	logic               tick_expired;

	assign take = valid_s1 && out_free;

	// the length byte takes effect on the byte that carries it
	assign total_next = (byte_count_q == LENGTH_INDEX)
		? ({1'b0, item_s1.data_byte} + HEADER_EXTRA) : packet_total_q;
	assign idx_plus     = {1'b0, byte_count_q} + 10'd1;
	assign is_last      = (idx_plus == {1'b0, total_next});
	assign tick_next    = (tick_count_q == TICK_MAX) ? tick_count_q : tick_count_q + 16'd1;
	assign tick_expired = (tick_next >= timeout_limit_q);

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (receiving_q) begin
			case (item_s1.action)
				ACT_BYTE: begin
					res_valid          = 1'b1;
					res.rx_byte        = item_s1.data_byte;
					res.byte_index     = byte_count_q;
					res.last           = is_last;
					res.checksum_error = is_last && (~running_sum_q != item_s1.data_byte);
				end
				ACT_TICK: begin
					res_valid      = tick_expired;
					res.byte_index = byte_count_q;
					res.last       = 1'b1;
					res.timed_out  = 1'b1;
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_limit_q <= TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q    <= 1'b0;
			byte_count_q   <= '0;
			packet_total_q <= HEADER_EXTRA;
			running_sum_q  <= '0;
			tick_count_q   <= '0;
		end else if (take) begin
			case (item_s1.action)
				ACT_START: begin
					receiving_q    <= 1'b1;
					byte_count_q   <= '0;
					packet_total_q <= HEADER_EXTRA;
					running_sum_q  <= '0;
					tick_count_q   <= '0;
				end
				ACT_BYTE: begin
					if (receiving_q) begin
						tick_count_q   <= '0;
						packet_total_q <= total_next;
						byte_count_q   <= idx_plus[INDEX_W-1:0];
						if (is_last) begin
							receiving_q <= 1'b0;
						end else if (byte_count_q >= SUM_FIRST) begin
							running_sum_q <= running_sum_q + item_s1.data_byte;
						end
					end
				end
				ACT_TICK: begin
					if (receiving_q) begin
						tick_count_q <= tick_next;
						if (tick_expired) begin
							receiving_q <= 1'b0;
						end
					end
				end
				default: begin
					receiving_q <= receiving_q;
				end
			endcase
		end
	end

endmodule

/* rtl/ssprx_out_stage.sv */
// Output register holding one result word until it is taken
module ssprx_out_stage
	import ssprx_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	output logic    out_free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res_q
);

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load) begin
			res_q <= res;
		end
	end

endmodule

/* rtl/servo_status_packet_receiver_top.sv */
// Servo status packet receiver: one input register, single-pass packet logic, output register.
// A start word arms the receiver; each byte word while armed yields a result word with the
// byte and its index, the byte at index 3 sets the packet length (value plus 4), and the final
// byte carries tlast with a checksum flag (inverted modulo-256 sum of the bytes from index 2 before it).
// Tick words count toward a per-byte timeout set by cfg_wr_data; reaching it gives a result
// with tlast and the timeout flag and returns to idle. Bytes and ticks while idle are dropped.
// One word is taken every clock unless a held result blocks it: the packet logic works on the
// word in the input register and writes its result to the output register, which decouples
// the sides; a word that makes no result still waits while a result is held back by m_axis_tready.
module servo_status_packet_receiver_top
	import ssprx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,    // timeout_limit
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_axis_tuser,   // [1:0] action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] rx_byte, [16:8] byte_index, [23:17] zero
	output logic        m_axis_tlast,
	output logic [1:0]  m_axis_tuser    // [0] checksum_error, [1] timed_out
);

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    take;
	logic    out_free;
	logic    res_valid;
	result_t res;
	result_t res_q;

	assign in_item.action    = s_axis_tuser;
	assign in_item.data_byte = s_axis_tdata;

	ssprx_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ssprx_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.out_free    (out_free),
		.take        (take),
		.res_valid   (res_valid),
		.res         (res)
	);

	ssprx_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && res_valid),
		.res       (res),
		.out_free  (out_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res_q     (res_q)
	);

	assign m_axis_tdata = {7'd0, res_q.byte_index, res_q.rx_byte};
	assign m_axis_tlast = res_q.last;
	assign m_axis_tuser = {res_q.timed_out, res_q.checksum_error};

endmodule

/* rtl/servo_status_packet_receiver_top_chk.sv */
// Port-level checker for the servo status packet receiver, bound to the top level
`include "servo_status_packet_receiver_top_assert.svh"

module servo_status_packet_receiver_top_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic [1:0]  m_axis_tuser
);

	`SSPRX_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")
	`SSPRX_ASSERT_OUT(a_timeout_last, !m_axis_tuser[1] || m_axis_tlast, "timeout word without tlast")
	`SSPRX_ASSERT_OUT(a_flags_apart, !(m_axis_tuser[0] && m_axis_tuser[1]), "checksum and timeout flags together")
	`SSPRX_ASSERT_OUT(a_timeout_byte, !m_axis_tuser[1] || (m_axis_tdata[7:0] == 8'd0), "timeout word carries a byte")
	`SSPRX_ASSERT_OUT(a_index_range, m_axis_tdata[16:8] <= 9'd258, "byte index beyond longest packet")

endmodule

bind servo_status_packet_receiver_top servo_status_packet_receiver_top_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

/* tb/sv/servo_status_packet_receiver_top_test.sv */
// Self-checking testbench for the servo status packet receiver top level
`timescale 1ns / 1ps

module servo_status_packet_receiver_top_test;
	import ssprx_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int unsigned IDLE_LIMIT  = 1000;
	localparam int unsigned HOLD_CYCLES = 6;
	localparam int unsigned PHASE_WORDS = 50;
	localparam int unsigned PROBE_TICKS = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [1:0]  m_axis_tuser;

	servo_status_packet_receiver_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state, mirrors the receiver
	logic               rx_armed = 1'b0;
	logic [INDEX_W-1:0] next_index = '0;
	logic [INDEX_W-1:0] frame_total = HEADER_EXTRA;
	logic [BYTE_W-1:0]  frame_sum = '0;
	logic [TICK_W-1:0]  wait_ticks = '0;
	logic [TICK_W-1:0]  timeout_q = TIMEOUT_RESET;

	result_t     awaited_results[$];
	int unsigned mismatches = 0;
	int unsigned words_counted = 0;
	bit          quiet = 1'b0;
	int unsigned stall_left = 0;
	int unsigned idle_cycles = 0;

	task automatic predict_word(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] data,
			output bit used);
		result_t            r;
		logic [INDEX_W-1:0] idx;
		logic               fin;
		used = 1'b1;
		if (act == ACT_START) begin
			rx_armed    = 1'b1;
			next_index  = '0;
			frame_total = HEADER_EXTRA;
			frame_sum   = '0;
			wait_ticks  = '0;
		end else if (!rx_armed || act == ACT_UNUSED) begin
			used = 1'b0;
		end else if (act == ACT_BYTE) begin
			idx        = next_index;
			wait_ticks = '0;
			if (idx == LENGTH_INDEX)
				frame_total = {1'b0, data} + HEADER_EXTRA;
			fin = (idx + 9'd1 == frame_total);
			r.rx_byte        = data;
			r.byte_index     = idx;
			r.last           = fin;
			r.checksum_error = fin && ((~frame_sum) != data);
			r.timed_out      = 1'b0;
			if (fin)
				rx_armed = 1'b0;
			else if (idx >= SUM_FIRST)
				frame_sum = frame_sum + data;
			next_index = idx + 9'd1;
			awaited_results.push_back(r);
		end else begin
			if (wait_ticks != TICK_MAX)
				wait_ticks = wait_ticks + 16'd1;
			if (wait_ticks >= timeout_q) begin
				rx_armed         = 1'b0;
				r.rx_byte        = '0;
				r.byte_index     = next_index;
				r.last           = 1'b1;
				r.checksum_error = 1'b0;
				r.timed_out      = 1'b1;
				awaited_results.push_back(r);
			end
		end
	endtask

	task automatic push_word(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] data);
		int unsigned gap;
		bit          used;
		gap = quiet ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= data;
		do @(posedge clk); while (!s_axis_tready);
		predict_word(act, data, used);
		if (used)
			words_counted++;
	endtask

	// Let every word in flight come out before touching the register
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (HOLD_CYCLES) @(posedge clk);
	endtask

	task automatic set_timeout(input logic [TICK_W-1:0] limit);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= limit;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		timeout_q = limit;
	endtask

	// Start word, then a whole status packet; ticks below the limit before each byte
	task automatic send_packet(input int unsigned len, input bit corrupt, input int unsigned tick_max,
			input bit noise);
		logic [BYTE_W-1:0] sum, b, id, err;
		int unsigned       total, i, t;
		total = len + 4;
		sum   = '0;
		err   = corrupt ? 8'($urandom_range(1, 255)) : 8'd0;
		// with a zero length the length byte doubles as the checksum
		if (len == 0)
			id = corrupt ? 8'($urandom_range(0, 254)) : 8'hFF;
		else
			id = 8'($urandom_range(0, 255));
		push_word(ACT_START, 8'($urandom));
		for (i = 0; i < total; i++) begin
			t = $urandom_range(0, tick_max);
			repeat (t) push_word(ACT_TICK, 8'($urandom));
			if (noise && $urandom_range(0, 19) == 0)
				push_word(ACT_UNUSED, 8'($urandom));
			if (i == 3)
				b = 8'(len);
			else if (i == total - 1)
				b = (~sum) ^ err;
			else if (i < 2)
				b = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'hFF;
			else if (i == 2)
				b = id;
			else
				b = 8'($urandom);
			if (i >= 2 && i < total - 1)
				sum = sum + b;
			push_word(ACT_BYTE, b);
		end
	endtask

	// A few bytes, then ticks until the wait runs out
	task automatic send_stalled(input int unsigned nbytes);
		int unsigned i, n;
		push_word(ACT_START, 8'($urandom));
		for (i = 0; i < nbytes; i++)
			push_word(ACT_BYTE, (i == 3) ? 8'hFF : 8'($urandom));
		n = (timeout_q == 0) ? 1 : timeout_q;
		repeat (n) push_word(ACT_TICK, 8'($urandom));
		push_word(ACT_TICK, 8'($urandom));
	endtask

	task automatic test_idle_words;
		push_word(ACT_BYTE, 8'h00);
		push_word(ACT_BYTE, 8'hFF);
		push_word(ACT_TICK, 8'hA5);
		push_word(ACT_UNUSED, 8'h5A);
	endtask

	task automatic test_checksum;
		send_packet(2, 1'b0, 1, 1'b0);
		send_packet(2, 1'b1, 1, 1'b0);
		send_packet(0, 1'b0, 0, 1'b0);
		send_packet(0, 1'b1, 0, 1'b0);
		// restart in the middle of a packet, with an unused code while armed
		push_word(ACT_START, 8'h00);
		push_word(ACT_BYTE, 8'hFF);
		push_word(ACT_UNUSED, 8'hFF);
		push_word(ACT_BYTE, 8'hFF);
		send_packet(1, 1'b0, 0, 1'b0);
		push_word(ACT_BYTE, 8'h12);
	endtask

	// Long waits well short of the reset limit leave the packet armed
	task automatic test_default_timeout;
		quiet = 1'b1;
		push_word(ACT_START, 8'h00);
		repeat (PROBE_TICKS) push_word(ACT_TICK, 8'h00);
		push_word(ACT_BYTE, 8'hFF);
		repeat (PROBE_TICKS) push_word(ACT_TICK, 8'hFF);
		quiet = 1'b0;
	endtask

	task automatic test_limit_extremes;
		set_timeout(16'd0);
		send_stalled(0);
		set_timeout(16'd1);
		send_stalled(1);
		send_packet(3, 1'b0, 0, 1'b0);
		set_timeout(TICK_MAX);
		quiet = 1'b1;
		push_word(ACT_START, 8'h00);
		repeat (PROBE_TICKS) push_word(ACT_TICK, 8'h00);
		push_word(ACT_BYTE, 8'h00);
		repeat (PROBE_TICKS) push_word(ACT_TICK, 8'h00);
		quiet = 1'b0;
	endtask

	task automatic test_random_traffic;
		logic [TICK_W-1:0] phase_limits[7];
		int unsigned       p, target, pick, tmax, k, i;
		phase_limits = '{16'd1, TICK_MAX, TIMEOUT_RESET, 16'd3, 16'd7,
			16'($urandom_range(1, 40)), 16'($urandom_range(1, 65535))};
		for (p = 0; p < 7; p++) begin
			set_timeout(phase_limits[p]);
			tmax   = (timeout_q - 1 < 4) ? timeout_q - 1 : 4;
			target = words_counted + PHASE_WORDS;
			if (p == 1)
				send_packet(255, 1'b0, 0, 1'b1);
			while (words_counted < target) begin
				quiet = ($urandom_range(0, 3) == 0);
				pick  = $urandom_range(0, 99);
				if (pick < 65) begin
					send_packet($urandom_range(0, 8), $urandom_range(0, 6) == 0, tmax, 1'b1);
				end else if (pick < 75) begin
					send_packet($urandom_range(9, 40), $urandom_range(0, 6) == 0, tmax, 1'b1);
				end else if (pick < 85 || (pick >= 93 && timeout_q > 64)) begin
					// broken packet, left for the next start to drop
					k = $urandom_range(0, 6);
					push_word(ACT_START, 8'($urandom));
					for (i = 0; i < k; i++)
						push_word(ACT_BYTE, 8'($urandom));
				end else if (pick < 93) begin
					k = $urandom_range(1, 4);
					for (i = 0; i < k; i++)
						push_word(ACT_WIDTH_RAND(), 8'($urandom));
				end else begin
					send_stalled($urandom_range(0, 5));
				end
			end
		end
		quiet = 1'b0;
	endtask

	function automatic logic [ACTION_W-1:0] ACT_WIDTH_RAND();
		return ACTION_W'($urandom_range(1, 3));
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_words();
		test_default_timeout();
		test_checksum();
		test_limit_extremes();
		test_random_traffic();
		drain();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Result side: random hold-off after each accepted word
	always @(posedge clk) begin
		int unsigned w;
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			if (stall_left == 1)
				m_axis_tready <= 1'b1;
		end else if (m_axis_tvalid && m_axis_tready) begin
			w = quiet ? 0 : $urandom_range(0, 5);
			if (w != 0) begin
				m_axis_tready <= 1'b0;
				stall_left    <= w;
			end
		end else if (!m_axis_tready) begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected word, expected none actual %h last %b user %b",
					$time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				check_field("rx_byte", 16'(want.rx_byte), 16'(m_axis_tdata[7:0]));
				check_field("byte_index", 16'(want.byte_index), 16'(m_axis_tdata[16:8]));
				check_field("last", 16'(want.last), 16'(m_axis_tlast));
				check_field("checksum_error", 16'(want.checksum_error), 16'(m_axis_tuser[0]));
				check_field("timed_out", 16'(want.timed_out), 16'(m_axis_tuser[1]));
			end
		end
	end

	// Watchdog: stalled handshakes on both sides end the run
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
